@@ rtl/usvg_pkg.sv @@
package usvg_pkg;

  localparam int DivSteps    = 41;
  localparam int CordicSteps = 16;
  localparam int DivLanes    = 4;

  localparam int LaneTheta = 0;
  localparam int LanePhi   = 1;
  localparam int LaneTexV  = 2;
  localparam int LaneTexU  = 3;

  localparam logic signed [26:0] CordicGain = 27'sd10188014;

  localparam logic [29:0] AtanTurn [CordicSteps] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861
  };

  typedef enum logic [2:0] {
    CFG_RADIUS   = 3'd0,
    CFG_RINGS    = 3'd1,
    CFG_SEGMENTS = 3'd2,
    CFG_NORMALS  = 3'd3,
    CFG_TEXCOORD = 3'd4
  } cfg_idx_e;

  // remainder and a combined numerator/quotient shift word
  typedef struct packed {
    logic [8:0]  rem;
    logic [40:0] nq;
  } div_lane_t;

  typedef struct packed {
    logic [7:0]                ring;
    logic [7:0]                seg;
    div_lane_t [DivLanes-1:0]  lane;
  } div_stage_t;

  typedef struct packed {
    logic signed [26:0] x;
    logic signed [26:0] y;
    logic signed [32:0] z;
  } cordic_vec_t;

  typedef struct packed {
    logic [7:0]  ring;
    logic [7:0]  seg;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } side_t;

  typedef struct packed {
    cordic_vec_t theta;
    cordic_vec_t phi;
    logic [1:0]  quad_theta;
    logic [1:0]  quad_phi;
    side_t       side;
  } cordic_stage_t;

endpackage

@@ rtl/uv_sphere_vertex_generator.sv @@
// Pipeline from input request to result: 41 divider cells,
// 16 CORDIC cells, 4 product and output stages.
// Throughput: one request per cycle; the whole chain advances whenever the
// output register is empty or being taken.
// Reset clears all valid bits and loads the register defaults.
module uv_sphere_vertex_generator
  import usvg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // ring_index, segment_index
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
  // vertex_number, tri_far, tri_diag, zero pad
  output logic [183:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser, // emits_triangles
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  logic [15:0] radius_q;
  logic [7:0]  ring_cnt_q, seg_cnt_q;
  logic        normals_on_q, tex_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= 16'd256;
      ring_cnt_q   <= 8'd16;
      seg_cnt_q    <= 8'd16;
      normals_on_q <= 1'b1;
      tex_on_q     <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RADIUS:   radius_q     <= cfg_data_i;
        CFG_RINGS:    ring_cnt_q   <= cfg_data_i[7:0];
        CFG_SEGMENTS: seg_cnt_q    <= cfg_data_i[7:0];
        CFG_NORMALS:  normals_on_q <= cfg_data_i[0];
        CFG_TEXCOORD: tex_on_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [7:0] rings, segs;
  assign rings = (ring_cnt_q == 8'd0) ? 8'd1 : ring_cnt_q;
  assign segs  = (seg_cnt_q == 8'd0) ? 8'd1 : seg_cnt_q;

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // divider chain
  div_stage_t div_s [DivSteps+1];
  logic       div_v [DivSteps+1];
  logic [7:0] in_ring, in_seg;

  assign in_ring = s_axis_tdata[7:0];
  assign in_seg  = s_axis_tdata[15:8];

  always_comb begin
    div_s[0].ring                = in_ring;
    div_s[0].seg                 = in_seg;
    div_s[0].lane[LaneTheta].rem = '0;
    div_s[0].lane[LaneTheta].nq  = {1'b0, in_ring, 24'd0, rings};
    div_s[0].lane[LanePhi].rem   = '0;
    div_s[0].lane[LanePhi].nq    = {in_seg, 25'd0, segs};
    div_s[0].lane[LaneTexV].rem  = '0;
    div_s[0].lane[LaneTexV].nq   = {16'd0, in_ring, 9'd0, rings};
    div_s[0].lane[LaneTexU].rem  = '0;
    div_s[0].lane[LaneTexU].nq   = {16'd0, in_seg, 9'd0, segs};
  end
  assign div_v[0] = s_axis_tvalid;

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    usvg_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (adv),
      .valid_i    (div_v[k]),
      .stage_i    (div_s[k]),
      .div_ring_i ({rings, 1'b0}),
      .div_seg_i  ({segs, 1'b0}),
      .valid_o    (div_v[k+1]),
      .stage_o    (div_s[k+1])
    );
  end

  // CORDIC chain
  cordic_stage_t cor_s [CordicSteps+1];
  logic          cor_v [CordicSteps+1];
  logic [31:0]   theta, phi;
  logic [24:0]   qv, qu;

  assign theta = div_s[DivSteps].lane[LaneTheta].nq[31:0];
  assign phi   = div_s[DivSteps].lane[LanePhi].nq[31:0];
  assign qv    = div_s[DivSteps].lane[LaneTexV].nq[24:0];
  assign qu    = div_s[DivSteps].lane[LaneTexU].nq[24:0];

  always_comb begin
    cor_s[0].theta.x    = CordicGain;
    cor_s[0].theta.y    = '0;
    cor_s[0].theta.z    = $signed({3'b000, theta[29:0]});
    cor_s[0].phi.x      = CordicGain;
    cor_s[0].phi.y      = '0;
    cor_s[0].phi.z      = $signed({3'b000, phi[29:0]});
    cor_s[0].quad_theta = theta[31:30];
    cor_s[0].quad_phi   = phi[31:30];
    cor_s[0].side.ring  = div_s[DivSteps].ring;
    cor_s[0].side.seg   = div_s[DivSteps].seg;
    cor_s[0].side.tex_v = (|qv[24:17]) ? 17'h1FFFF : qv[16:0];
    cor_s[0].side.tex_u = (|qu[24:17]) ? 17'h1FFFF : qu[16:0];
  end
  assign cor_v[0] = div_v[DivSteps];

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    usvg_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .step_i  (4'(k)),
      .valid_i (cor_v[k]),
      .stage_i (cor_s[k]),
      .valid_o (cor_v[k+1]),
      .stage_o (cor_s[k+1])
    );
  end

  function automatic logic signed [15:0] clamp_q14(logic signed [31:0] v);
    if (v > 32'sd16384) begin
      return 16'sd16384;
    end else if (v < -32'sd16384) begin
      return -16'sd16384;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] round_q14(logic signed [26:0] v);
    logic signed [26:0] t;
    t = (v + 27'sd512) >>> 10;
    return clamp_q14(32'(t));
  endfunction

  // tail: trig, products, output
  cordic_stage_t      cf;
  logic signed [15:0] c_t, s_t, c_p, s_p;
  logic signed [15:0] ct_d, st_d, cp_d, sp_d;

  assign cf  = cor_s[CordicSteps];
  assign c_t = round_q14(cf.theta.x);
  assign s_t = round_q14(cf.theta.y);
  assign c_p = round_q14(cf.phi.x);
  assign s_p = round_q14(cf.phi.y);

  always_comb begin
    case (cf.quad_theta)
      2'd0:    begin ct_d = c_t;  st_d = s_t;  end
      2'd1:    begin ct_d = -s_t; st_d = c_t;  end
      2'd2:    begin ct_d = -c_t; st_d = -s_t; end
      default: begin ct_d = s_t;  st_d = -c_t; end
    endcase
    case (cf.quad_phi)
      2'd0:    begin cp_d = c_p;  sp_d = s_p;  end
      2'd1:    begin cp_d = -s_p; sp_d = c_p;  end
      2'd2:    begin cp_d = -c_p; sp_d = -s_p; end
      default: begin cp_d = s_p;  sp_d = -c_p; end
    endcase
  end

  logic               p1_v_q, p2_v_q, p3_v_q;
  side_t              p1_side_q, p2_side_q, p3_side_q;
  logic signed [15:0] ct_q, st_q, cp_q, sp_q, ct2_q;
  logic signed [31:0] stsp_q, stcp_q;
  logic signed [32:0] rct_q;
  logic signed [48:0] rstsp_q, rstcp_q;
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic [16:0]        posy_q;
  logic signed [16:0] r_s;
  logic signed [32:0] rct_rnd;
  logic signed [31:0] stsp_rnd, stcp_rnd;

  assign r_s      = $signed({1'b0, radius_q});
  assign rct_rnd  = (rct_q + 33'sd8192) >>> 14;
  assign stsp_rnd = (stsp_q + 32'sd8192) >>> 14;
  assign stcp_rnd = (stcp_q + 32'sd8192) >>> 14;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q        <= 1'b0;
      p2_v_q        <= 1'b0;
      p3_v_q        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      p1_v_q        <= cor_v[CordicSteps];
      p2_v_q        <= p1_v_q;
      p3_v_q        <= p2_v_q;
      m_axis_tvalid <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_side_q <= cf.side;
      ct_q      <= ct_d;
      st_q      <= st_d;
      cp_q      <= cp_d;
      sp_q      <= sp_d;

      p2_side_q <= p1_side_q;
      stsp_q    <= st_q * sp_q;
      stcp_q    <= st_q * cp_q;
      rct_q     <= r_s * ct_q;
      ct2_q     <= ct_q;

      p3_side_q <= p2_side_q;
      rstsp_q   <= r_s * stsp_q;
      rstcp_q   <= r_s * stcp_q;
      posy_q    <= rct_rnd[16:0];
      nx_q      <= clamp_q14(stsp_rnd);
      ny_q      <= ct2_q;
      nz_q      <= clamp_q14(stcp_rnd);
    end
  end

  logic signed [48:0] px_rnd, pz_rnd;
  logic [16:0]        tex_u, tex_v;
  logic [15:0]        nx_o, ny_o, nz_o, vn, far_o, diag_o;
  logic [16:0]        vn_full;
  logic               nrm_en, emit;

  assign px_rnd  = (rstsp_q + 49'sd134217728) >>> 28;
  assign pz_rnd  = (rstcp_q + 49'sd134217728) >>> 28;
  assign nrm_en  = normals_on_q && (radius_q != 16'd0);
  assign nx_o    = nrm_en ? nx_q : 16'd0;
  assign ny_o    = nrm_en ? ny_q : 16'd0;
  assign nz_o    = nrm_en ? nz_q : 16'd0;
  assign tex_u   = tex_on_q ? p3_side_q.tex_u : 17'd0;
  assign tex_v   = tex_on_q ? p3_side_q.tex_v : 17'd0;
  assign vn_full = p3_side_q.ring * ({1'b0, segs} + 9'd1) + {9'd0, p3_side_q.seg};
  assign vn      = vn_full[15:0];
  assign emit    = p3_side_q.ring < rings;
  assign far_o   = emit ? 16'(vn + {8'd0, segs} + 16'd1) : 16'd0;
  assign diag_o  = emit ? 16'(vn + {8'd0, segs}) : 16'd0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= {3'b000, diag_o, far_o, vn, tex_v, tex_u, nz_o, ny_o, nx_o,
                       pz_rnd[16:0], posy_q, px_rnd[16:0]};
      m_axis_tuser <= emit;
    end
  end

  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && p3_v_q) |=> m_axis_tvalid)
    else $error("result lost at output stage");

  a_tri_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[180:149] == 32'd0))
    else $error("triangle indices set on last ring");

  a_norm_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !normals_on_q) |-> (m_axis_tdata[98:51] == 48'd0))
    else $error("normals present while disabled");

  a_tex_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !tex_on_q) |-> (m_axis_tdata[132:99] == 34'd0))
    else $error("texture coordinates present while disabled");

endmodule

@@ rtl/usvg_div_cell.sv @@
module usvg_div_cell
  import usvg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  div_stage_t stage_i,
  input  logic [8:0] div_ring_i,
  input  logic [8:0] div_seg_i,
  output logic       valid_o,
  output div_stage_t stage_o
);

  div_stage_t stage_d, stage_q;
  logic       valid_q;

  function automatic div_lane_t div_step(div_lane_t l, logic [8:0] d);
    logic [9:0] t;
    logic       ge;
    div_lane_t  r;
    t     = {l.rem, l.nq[40]};
    ge    = (t >= {1'b0, d});
    r.rem = ge ? 9'(t - {1'b0, d}) : t[8:0];
    r.nq  = {l.nq[39:0], ge};
    return r;
  endfunction

  always_comb begin
    stage_d = stage_i;
    for (int l = 0; l < DivLanes; l++) begin
      if (l == LaneTheta || l == LaneTexV) begin
        stage_d.lane[l] = div_step(stage_i.lane[l], div_ring_i);
      end else begin
        stage_d.lane[l] = div_step(stage_i.lane[l], div_seg_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/usvg_cordic_cell.sv @@
module usvg_cordic_cell
  import usvg_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [3:0]    step_i,
  input  logic          valid_i,
  input  cordic_stage_t stage_i,
  output logic          valid_o,
  output cordic_stage_t stage_o
);

  cordic_stage_t stage_d, stage_q;
  logic          valid_q;

  function automatic cordic_vec_t rotate(cordic_vec_t v, logic [3:0] s);
    logic signed [26:0] dx, dy;
    logic signed [32:0] a;
    cordic_vec_t        r;
    dx = v.y >>> s;
    dy = v.x >>> s;
    a  = $signed({3'b000, AtanTurn[s]});
    if (v.z >= 0) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - a;
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + a;
    end
    return r;
  endfunction

  always_comb begin
    stage_d       = stage_i;
    stage_d.theta = rotate(stage_i.theta, step_i);
    stage_d.phi   = rotate(stage_i.phi, step_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ tb/tb_uv_sphere_vertex_generator.sv @@
`timescale 1ns / 100ps

class vertex_scoreboard;
  logic [183:0] exp_data_q[$];
  logic         exp_tri_q[$];
  int           errors;

  function void note_request(logic [183:0] d, logic t);
    exp_data_q.push_back(d);
    exp_tri_q.push_back(t);
  endfunction

  function void check_result(logic [183:0] d, logic t);
    logic [183:0] e;
    logic         et;
    if (exp_data_q.size() == 0) begin
      $display("%0t unexpected result %h", $time, d);
      errors++;
      return;
    end
    e  = exp_data_q.pop_front();
    et = exp_tri_q.pop_front();
    if (e[16:0] !== d[16:0])
      $display("%0t pos_x exp %h got %h", $time, e[16:0], d[16:0]);
    if (e[33:17] !== d[33:17])
      $display("%0t pos_y exp %h got %h", $time, e[33:17], d[33:17]);
    if (e[50:34] !== d[50:34])
      $display("%0t pos_z exp %h got %h", $time, e[50:34], d[50:34]);
    if (e[66:51] !== d[66:51])
      $display("%0t norm_x exp %h got %h", $time, e[66:51], d[66:51]);
    if (e[82:67] !== d[82:67])
      $display("%0t norm_y exp %h got %h", $time, e[82:67], d[82:67]);
    if (e[98:83] !== d[98:83])
      $display("%0t norm_z exp %h got %h", $time, e[98:83], d[98:83]);
    if (e[115:99] !== d[115:99])
      $display("%0t tex_u exp %h got %h", $time, e[115:99], d[115:99]);
    if (e[132:116] !== d[132:116])
      $display("%0t tex_v exp %h got %h", $time, e[132:116], d[132:116]);
    if (e[148:133] !== d[148:133])
      $display("%0t vertex_number exp %h got %h", $time, e[148:133], d[148:133]);
    if (e[164:149] !== d[164:149])
      $display("%0t tri_far exp %h got %h", $time, e[164:149], d[164:149]);
    if (e[180:165] !== d[180:165])
      $display("%0t tri_diag exp %h got %h", $time, e[180:165], d[180:165]);
    if (e[183:181] !== d[183:181])
      $display("%0t pad exp %h got %h", $time, e[183:181], d[183:181]);
    if (et !== t)
      $display("%0t emits_triangles exp %b got %b", $time, et, t);
    if (e !== d || et !== t) errors++;
  endfunction
endclass

module tb_uv_sphere_vertex_generator;
  import usvg_pkg::*;

  localparam int Latency   = 61;
  localparam int WatchdogLimit = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [183:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;

  uv_sphere_vertex_generator dut (.*);

  initial forever #4 clk_i = ~clk_i;

  vertex_scoreboard sb = new();

  logic [15:0] radius_q;
  logic [7:0]  rings_q, segs_q;
  logic        norm_en_q, tex_en_q;
  int          send_idle_pct, recv_idle_pct;
  int          quiet_cycles;
  int          n_sent, n_recv;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_q14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy, cc, ss;
    x = 10188014; y = 0; z = ang[29:0];
    for (int i = 0; i < CordicSteps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanTurn[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanTurn[i]);
      end
    end
    cc = clamp_q14(round_shr(x, 10));
    ss = clamp_q14(round_shr(y, 10));
    case (ang[31:30])
      2'd0: begin c = cc;  s = ss;  end
      2'd1: begin c = -ss; s = cc;  end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endtask

  function automatic logic [16:0] tex_ratio(longint idx, longint cnt);
    longint t;
    t = ((idx <<< 17) + cnt) / (2 * cnt);
    return (t > 131071) ? 17'h1ffff : t[16:0];
  endfunction

  task automatic predict_vertex(input logic [7:0] ring, input logic [7:0] seg,
                                output logic [183:0] d, output logic emit);
    longint rings, segs, r, ct, st, cp, sp, nx, ny, nz;
    logic [31:0] theta, phi;
    logic [15:0] vn;
    longint tmp;
    rings = (rings_q == 0) ? 1 : rings_q;
    segs  = (segs_q == 0) ? 1 : segs_q;
    r = radius_q;
    tmp = ((longint'(ring) <<< 32) + rings) / (2 * rings);
    theta = tmp[31:0];
    tmp = ((longint'(seg) <<< 33) + segs) / (2 * segs);
    phi = tmp[31:0];
    sin_cos(theta, ct, st);
    sin_cos(phi, cp, sp);
    nx = 0; ny = 0; nz = 0;
    if (norm_en_q && r != 0) begin
      nx = clamp_q14(round_shr(st * sp, 14));
      ny = ct;
      nz = clamp_q14(round_shr(st * cp, 14));
    end
    d = '0;
    tmp = round_shr(r * st * sp, 28); d[16:0]  = tmp[16:0];
    tmp = round_shr(r * ct, 14);      d[33:17] = tmp[16:0];
    tmp = round_shr(r * st * cp, 28); d[50:34] = tmp[16:0];
    d[66:51] = nx[15:0];
    d[82:67] = ny[15:0];
    d[98:83] = nz[15:0];
    if (tex_en_q) begin
      d[115:99]  = tex_ratio(seg, segs);
      d[132:116] = tex_ratio(ring, rings);
    end
    tmp = ring * (segs + 1) + seg;
    vn = tmp[15:0];
    emit = (ring < rings);
    d[148:133] = vn;
    if (emit) begin
      d[164:149] = vn + 16'(segs) + 16'd1;
      d[180:165] = vn + 16'(segs);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_RADIUS:   radius_q  = val;
      CFG_RINGS:    rings_q   = val[7:0];
      CFG_SEGMENTS: segs_q    = val[7:0];
      CFG_NORMALS:  norm_en_q = val[0];
      CFG_TEXCOORD: tex_en_q  = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] r, logic [7:0] rg, logic [7:0] sg,
                           logic ne, logic te);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_RINGS, {8'h00, rg});
    write_reg(CFG_SEGMENTS, {8'h00, sg});
    write_reg(CFG_NORMALS, {15'h0, ne});
    write_reg(CFG_TEXCOORD, {15'h0, te});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_point(logic [7:0] ring, logic [7:0] seg);
    logic [183:0] d;
    logic         t;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {seg, ring};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_vertex(ring, seg, d, t);
    sb.note_request(d, t);
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.exp_data_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  task automatic random_points(int n);
    logic [7:0] rg, sg;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) begin
        rg = 8'($urandom_range((rings_q == 0) ? 1 : rings_q));
        sg = 8'($urandom_range((segs_q == 0) ? 1 : segs_q));
      end else begin
        rg = 8'($urandom); sg = 8'($urandom);
      end
      send_point(rg, sg);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        n_recv++;
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("** uv_sphere_vertex_generator: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    quiet_cycles = 0; n_sent = 0; n_recv = 0;
    radius_q = 16'd256; rings_q = 8'd16; segs_q = 8'd16;
    norm_en_q = 1'b1; tex_en_q = 1'b1;
    send_idle_pct = 25; recv_idle_pct = 77;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults, poles, equator, out-of-range indices
    send_point(8'd0, 8'd0);
    send_point(8'd16, 8'd16);
    send_point(8'd8, 8'd4);
    send_point(8'd15, 8'd15);
    send_point(8'd255, 8'd255);
    send_point(8'd17, 8'd0);
    send_point(8'd0, 8'd200);
    send_point(8'd170, 8'd85);
    drain();
    configure(16'hffff, 8'd255, 8'd255, 1'b1, 1'b1);
    send_point(8'd0, 8'd0);
    send_point(8'd127, 8'd64);
    send_point(8'd255, 8'd255);
    send_point(8'd254, 8'd191);
    drain();
    configure(16'h0000, 8'd0, 8'd0, 1'b1, 1'b0);
    send_point(8'd0, 8'd0);
    send_point(8'd1, 8'd1);
    send_point(8'd255, 8'd128);
    drain();
    configure(16'd1000, 8'd1, 8'd1, 1'b0, 1'b1);
    send_point(8'd0, 8'd1);
    send_point(8'd1, 8'd0);
    send_point(8'd2, 8'd3);
    drain();

    configure(16'd256, 8'd24, 8'd32, 1'b1, 1'b1);
    random_points(500);
    drain();
    send_idle_pct = 77; recv_idle_pct = 25;
    configure(16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    random_points(250);
    drain();
    configure(16'($urandom), 8'd3, 8'd255, 1'b1, 1'b1);
    random_points(250);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    configure(16'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b1);
    random_points(500);
    drain();

    $display("Covered %0d grid points (%0d results) over several radius/count/enable settings,",
             n_sent, n_recv);
    $display("including extreme counts, zero radius, wrapped indices and idle/stall mixes.");
    if (sb.errors == 0 && sb.exp_data_q.size() == 0)
      $display("** uv_sphere_vertex_generator: PASSED **");
    else
      $display("** uv_sphere_vertex_generator: FAILED **");
    $finish;
  end
endmodule
